// File: hw/rtl/acs_pkg.sv
package acs_pkg;
    localparam int PC_W = 16;
    localparam int REG_W = 32;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_EXEC  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_BAD   = 2'd3;

    localparam logic [2:0] ST_EXEC    = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_ILLEGAL = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_WRITTEN = 3'd4;
    localparam logic [2:0] ST_RESET   = 3'd5;

    localparam logic [1:0] FLAG_CLEAR   = 2'd0;
    localparam logic [1:0] FLAG_LESS    = 2'd1;
    localparam logic [1:0] FLAG_GREATER = 2'd2;
    localparam logic [1:0] FLAG_EQUAL   = 2'd3;

    localparam logic [7:0] OP_HALT = 8'd0;
    localparam logic [7:0] OP_LDA  = 8'd4;
    localparam logic [7:0] OP_LDB  = 8'd5;
    localparam logic [7:0] OP_LDJ  = 8'd6;
    localparam logic [7:0] OP_STA  = 8'd8;
    localparam logic [7:0] OP_STB  = 8'd9;
    localparam logic [7:0] OP_STJ  = 8'd10;
    localparam logic [7:0] OP_ADDM = 8'd16;
    localparam logic [7:0] OP_ADDI = 8'd17;
    localparam logic [7:0] OP_SUBM = 8'd18;
    localparam logic [7:0] OP_SUBI = 8'd19;
    localparam logic [7:0] OP_DIVM = 8'd20;
    localparam logic [7:0] OP_DIVI = 8'd21;
    localparam logic [7:0] OP_MULM = 8'd22;
    localparam logic [7:0] OP_MULI = 8'd23;
    localparam logic [7:0] OP_ANDM = 8'd32;
    localparam logic [7:0] OP_ANDI = 8'd33;
    localparam logic [7:0] OP_ORM  = 8'd34;
    localparam logic [7:0] OP_ORI  = 8'd35;
    localparam logic [7:0] OP_NOT  = 8'd36;
    localparam logic [7:0] OP_XORM = 8'd37;
    localparam logic [7:0] OP_XORI = 8'd38;
    localparam logic [7:0] OP_SHL0 = 8'd39;
    localparam logic [7:0] OP_SHL1 = 8'd40;
    localparam logic [7:0] OP_SHR0 = 8'd41;
    localparam logic [7:0] OP_SHR1 = 8'd42;
    localparam logic [7:0] OP_CLRF = 8'd48;
    localparam logic [7:0] OP_CMP  = 8'd49;
    localparam logic [7:0] OP_JGT  = 8'd50;
    localparam logic [7:0] OP_JEQ  = 8'd51;
    localparam logic [7:0] OP_JLT  = 8'd52;
    localparam logic [7:0] OP_JMP  = 8'd53;
    localparam logic [7:0] OP_RET  = 8'd54;
    localparam logic [7:0] OP_CON0 = 8'd64;
    localparam logic [7:0] OP_CON1 = 8'd65;
    localparam logic [7:0] OP_CON2 = 8'd66;
    localparam logic [7:0] OP_CON3 = 8'd67;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pc_out;
        logic [31:0] acc_out;
        logic [31:0] aux_out;
        logic [31:0] link_out;
        logic [1:0]  flag_out;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } t_div_rsp;

    function automatic logic op_legal(input logic [7:0] op);
        return (op >= OP_LDA && op <= OP_LDJ) || (op >= OP_STA && op <= OP_STJ) ||
               (op >= OP_ADDM && op <= OP_MULI) || (op >= OP_ANDM && op <= OP_SHR1) ||
               (op >= OP_CLRF && op <= OP_RET) || (op >= OP_CON0 && op <= OP_CON3);
    endfunction
endpackage

// File: hw/rtl/acs_if.sv
interface acs_in_if;
    import acs_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface acs_out_if;
    import acs_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/accumulator_cpu_step_core.sv
// Accumulator machine, one instruction per step transfer.
// Input channel (i_in): action, address, write_byte. Output channel (o_out):
// status, pc_out, acc_out, aux_out, link_out, flag_out; one result per input.
// Byte memory is a single-port synchronous RAM with a registered read;
// the sequencer reads eight instruction bytes one per cycle, then the
// operand byte, then executes. An execute result passes through S_EXEC and
// S_OUT into the output register; a multiply adds the S_MUL state, a divide
// waits in S_DIV for the 32-step shift/subtract unit. Writes, register
// resets and unused actions go straight to S_OUT. Memory fetch through the
// single RAM port sets the step rate.
// One item is in flight at a time; the result sits in an output register
// and the next input is taken once it is transferred or in the same cycle.
// A receiver stall holds the result and the block.
// Reset (i_rst_n low, synchronous) clears registers, flag and PC; memory
// contents are undefined until written.
module accumulator_cpu_step_core #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    acs_in_if.sink    i_in,
    acs_out_if.source o_out
);
    import acs_pkg::*;

    localparam int AW = MEM_ADDR_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_OPER  = 4'd2;
    localparam logic [3:0] S_OPWT  = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [7:0] mem [2**AW];
    logic [7:0] r_rdata;
    logic [AW-1:0] mem_addr;
    logic       mem_we;
    logic [7:0] mem_wd;

    logic [3:0]  r_st;
    logic [3:0]  r_cnt;
    logic [63:0] r_insn;
    logic [7:0]  r_m;
    logic [31:0] r_a, r_b, r_j, r_mul;
    logic [15:0] r_pc;
    logic [1:0]  r_f;
    logic        r_ov;
    logic [2:0]  r_status;

    logic [7:0]  op;
    logic [23:0] p1;
    logic [31:0] p2, v, ea32;
    logic [15:0] pc_adv;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    assign op     = r_insn[7:0];
    assign p1     = r_insn[31:8];
    assign p2     = r_insn[63:32];
    assign ea32   = {8'd0, p1} + p2;
    assign v      = op[0] ? p2 : {24'd0, r_m};
    assign pc_adv = r_pc + 16'd8;

    assign i_in.ready  = (r_st == S_IDLE) && (!r_ov || o_out.ready);
    assign o_out.valid = r_ov;
    assign o_out.data  = {r_status, r_pc, r_a, r_b, r_j, r_f};

    always_comb begin
        mem_we   = 1'b0;
        mem_wd   = i_in.data.write_byte;
        mem_addr = AW'({16'd0, r_pc} + {28'd0, r_cnt});
        unique case (r_st)
            S_IDLE: begin
                mem_addr = AW'(i_in.data.address);
                mem_we   = i_in.valid && i_in.ready && (i_in.data.action == ACT_WRITE);
            end
            S_OPER: mem_addr = ea32[AW-1:0];
            S_EXEC: begin
                mem_addr = ea32[AW-1:0];
                mem_we   = (op == OP_STA) || (op == OP_STB) || (op == OP_STJ);
                mem_wd   = (op == OP_STA) ? r_a[7:0] : (op == OP_STB) ? r_b[7:0] : r_j[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rdata <= mem[mem_addr];
    end

    assign div_req.start = (r_st == S_EXEC) && (op == OP_DIVM || op == OP_DIVI) && (r_a != '0);
    assign div_req.num   = v;
    assign div_req.den   = r_a;

    acs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_mul <= v * r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_status <= ST_EXEC;
            r_a <= '0; r_b <= '0; r_j <= '0; r_pc <= '0; r_f <= FLAG_CLEAR;
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    unique case (i_in.data.action)
                        ACT_WRITE: begin
                            r_status <= ST_WRITTEN;
                            r_st <= S_OUT;
                        end
                        ACT_EXEC: begin
                            r_cnt <= 4'd0;
                            r_st  <= S_FETCH;
                        end
                        ACT_CLEAR: begin
                            r_a <= '0; r_b <= '0; r_j <= '0; r_pc <= '0;
                            r_f <= FLAG_CLEAR;
                            r_status <= ST_RESET;
                            r_st <= S_OUT;
                        end
                        default: begin
                            r_status <= ST_ILLEGAL;
                            r_st <= S_OUT;
                        end
                    endcase
                end
                S_FETCH: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt != 4'd0) begin
                        r_insn <= {r_rdata, r_insn[63:8]};
                    end
                    if (r_cnt == 4'd8) begin
                        r_st <= S_OPER;
                    end
                end
                S_OPER: r_st <= S_OPWT;
                S_OPWT: begin
                    r_m  <= r_rdata;
                    r_st <= S_EXEC;
                end
                S_EXEC: begin
                    r_status <= ST_EXEC;
                    r_st <= S_OUT;
                    if (op == OP_HALT) begin
                        r_status <= ST_HALT;
                    end else if (!op_legal(op)) begin
                        r_status <= ST_ILLEGAL;
                    end else begin
                        r_pc <= pc_adv;
                        priority case (op)
                            OP_LDA: r_a <= {24'd0, r_m};
                            OP_LDB: r_b <= {24'd0, r_m};
                            OP_LDJ: r_j <= {24'd0, r_m};
                            OP_ADDM, OP_ADDI: r_a <= v + r_a;
                            OP_SUBM, OP_SUBI: r_a <= v - r_a;
                            OP_DIVM, OP_DIVI: begin
                                if (r_a == '0) begin
                                    r_status <= ST_DIVZERO;
                                end else begin
                                    r_st <= S_DIV;
                                end
                            end
                            OP_MULM, OP_MULI: r_st <= S_MUL;
                            OP_ANDM, OP_ANDI: r_a <= v & r_a;
                            OP_ORM, OP_ORI: r_a <= v | r_a;
                            OP_NOT: r_a <= ~r_a;
                            OP_XORM: r_a <= {24'd0, r_m} ^ r_a;
                            OP_XORI: r_a <= p2 ^ r_a;
                            OP_SHL0, OP_SHL1:
                                r_a <= (r_a >= 32'd32) ? '0 : ({8'd0, p1} << r_a[4:0]);
                            OP_SHR0, OP_SHR1:
                                r_a <= (r_a >= 32'd32) ? '0 : ({8'd0, p1} >> r_a[4:0]);
                            OP_CLRF: r_f <= FLAG_CLEAR;
                            OP_CMP: r_f <= r_a[31] ? FLAG_LESS :
                                           (r_a != '0) ? FLAG_GREATER : FLAG_EQUAL;
                            OP_JGT, OP_JEQ, OP_JLT, OP_JMP: begin
                                if ((op == OP_JMP) || (op == OP_JGT && r_f == FLAG_GREATER) ||
                                    (op == OP_JEQ && r_f == FLAG_EQUAL) ||
                                    (op == OP_JLT && r_f == FLAG_LESS)) begin
                                    r_j  <= {16'd0, pc_adv};
                                    r_pc <= p2[15:0];
                                end
                            end
                            OP_RET: begin
                                r_j  <= {16'd0, pc_adv};
                                r_pc <= r_j[15:0];
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_a  <= r_mul;
                    r_st <= S_OUT;
                end
                S_DIV: if (div_rsp.done) begin
                    r_a  <= div_rsp.quo;
                    r_b  <= div_rsp.rem;
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ov || o_out.ready) begin
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/acs_div.sv
module acs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acs_pkg::t_div_req i_req,
    output acs_pkg::t_div_rsp o_rsp
);
    import acs_pkg::*;

    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [33:0] n_trial;
    logic [32:0] n_rsh;

    assign n_rsh   = {r_r, r_q[31]};
    assign n_trial = {1'b0, n_rsh} - {2'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.num;
            r_r <= '0;
            r_d <= i_req.den;
        end else if (r_busy) begin
            if (!n_trial[33]) begin
                r_r <= n_trial[31:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= n_rsh[31:0];
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == 6'd31);
    assign o_rsp.quo  = n_trial[33] ? {r_q[30:0], 1'b0} : {r_q[30:0], 1'b1};
    assign o_rsp.rem  = n_trial[33] ? n_rsh[31:0] : n_trial[31:0];
endmodule
